[sv/ffsa_pkg.sv]
// Package for the first-fit segment allocator: sizes, codes, state encoding
// and the structs shared by the top level, the segment table and the adder.
// No dependencies.
`default_nettype none

package ffsa_pkg;

  localparam int SEGMENTS = 64;
  localparam int ADDR_W   = 32;
  localparam int HDR_W    = 8;
  localparam int IDX_W    = $clog2(SEGMENTS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int ALU_W    = ADDR_W + 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NULL     = 2'd1,
    ST_NOMEM    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_HEAP_BASE    = 2'd0,
    REG_HEAP_LIMIT   = 2'd1,
    REG_HEADER_BYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FREE_MAX,
    S_SPLIT_TOP,
    S_SPLIT_LIM,
    S_SPLIT_NEW,
    S_SPLIT_OLD,
    S_APP_SUM,
    S_APP_TOP,
    S_APP_LIM,
    S_APP_NEW,
    S_APP_LINK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic              is_free;
    logic [IDX_W-1:0]  link;
  } entry_t;

  typedef struct packed {
    logic start;
    logic length;
    logic is_free;
    logic link;
  } wmask_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             borrow;
    logic             zero;
  } alu_res_t;

endpackage

`default_nettype wire

[sv/ffsa_alu.sv]
// Shared add / subtract-compare unit of the allocator sequencer.
// Depends on ffsa_pkg.
`default_nettype none

module ffsa_alu (
  input  logic [ffsa_pkg::ALU_W-1:0] a,
  input  logic [ffsa_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  output ffsa_pkg::alu_res_t         res
);
  import ffsa_pkg::*;

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   full;

  assign b_op = sub ? ~b : b;
  assign full = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};

  assign res.sum    = full[ALU_W-1:0];
  assign res.borrow = sub & ~full[ALU_W];
  assign res.zero   = (full[ALU_W-1:0] == '0);

endmodule

`default_nettype wire

[sv/ffsa_table.sv]
// Segment table: start, length, free mark and link memories with one
// masked write port and one registered read port. Depends on ffsa_pkg.
`default_nettype none

module ffsa_table (
  input  logic                       clk,
  input  logic [ffsa_pkg::IDX_W-1:0] rd_addr,
  output ffsa_pkg::entry_t           rd_data,
  input  logic [ffsa_pkg::IDX_W-1:0] wr_addr,
  input  ffsa_pkg::wmask_t           wr_mask,
  input  ffsa_pkg::entry_t           wr_data
);
  import ffsa_pkg::*;

  logic [ADDR_W-1:0] mem_start   [SEGMENTS];
  logic [ADDR_W-1:0] mem_length  [SEGMENTS];
  logic              mem_is_free [SEGMENTS];
  logic [IDX_W-1:0]  mem_link    [SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr_mask.start) begin
      mem_start[wr_addr] <= wr_data.start;
    end
    if (wr_mask.length) begin
      mem_length[wr_addr] <= wr_data.length;
    end
    if (wr_mask.is_free) begin
      mem_is_free[wr_addr] <= wr_data.is_free;
    end
    if (wr_mask.link) begin
      mem_link[wr_addr] <= wr_data.link;
    end
  end

  always_ff @(posedge clk) begin
    rd_data.start   <= mem_start[rd_addr];
    rd_data.length  <= mem_length[rd_addr];
    rd_data.is_free <= mem_is_free[rd_addr];
    rd_data.link    <= mem_link[rd_addr];
  end

endmodule

`default_nettype wire

[sv/first_fit_segment_allocator.sv]
// First-fit segment allocator top level: request sequencer, heap registers,
// output register. Depends on ffsa_pkg, ffsa_alu and ffsa_table.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   request  | in_valid / in_ready      | kind, request_size, release_address
//   result   | out_valid / out_ready    | granted_address, status
//   config   | cfg_write                | cfg_index, cfg_data
//
// A request with zero size, or a free on an empty table, finishes straight
// after the decision step; otherwise the list walk reads one table entry per cycle through the
// single read port, and each arithmetic append or split step uses the shared adder once.
// in_ready is high only while the sequencer is idle.
// A finished result sits in the output register until out_ready; the next
// request is taken meanwhile but cannot finish until that register frees.
// Reset is synchronous; the table needs no clearing pass after it.
`default_nettype none

module first_fit_segment_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [ffsa_pkg::ADDR_W-1:0] request_size,
  input  logic [ffsa_pkg::ADDR_W-1:0] release_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffsa_pkg::ADDR_W-1:0] granted_address,
  output logic [1:0]                  status,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [ffsa_pkg::ADDR_W-1:0] cfg_data
);
  import ffsa_pkg::*;

  state_t            state, state_next;
  logic              kind_q, kind_q_next;
  logic [ADDR_W-1:0] size_q, size_q_next;
  logic [ADDR_W-1:0] addr_q, addr_q_next;
  logic [IDX_W-1:0]  at, at_next;
  logic [CNT_W-1:0]  n, n_next;
  logic [ALU_W-1:0]  tmp, tmp_next;
  logic [ADDR_W-1:0] rem, rem_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  status_t           res_status, res_status_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [ADDR_W-1:0] heap_top, heap_top_next;
  logic [ADDR_W-1:0] largest_freed, largest_freed_next;
  logic [ADDR_W-1:0] heap_base, heap_base_next;
  logic [ADDR_W-1:0] heap_limit, heap_limit_next;
  logic [HDR_W-1:0]  header_bytes, header_bytes_next;
  logic              out_load;

  logic [ALU_W-1:0]  alu_a, alu_b;
  logic              alu_sub;
  alu_res_t          alu;

  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd;
  logic [IDX_W-1:0]  wr_addr;
  wmask_t            wr_mask;
  entry_t            wr_data;

  logic [CNT_W-1:0]  n_inc;
  logic              table_full;
  logic [IDX_W-1:0]  new_idx;

  ffsa_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu)
  );

  ffsa_table u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd),
    .wr_addr (wr_addr),
    .wr_mask (wr_mask),
    .wr_data (wr_data)
  );

  assign in_ready   = (state == S_IDLE);
  assign n_inc      = n + 1'b1;
  assign table_full = (count == CNT_W'(SEGMENTS));
  assign new_idx    = count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      tail          <= '0;
      heap_top      <= '0;
      largest_freed <= '0;
      heap_base     <= '0;
      heap_limit    <= '1;
      header_bytes  <= HDR_W'(32);
    end else begin
      state         <= state_next;
      count         <= count_next;
      tail          <= tail_next;
      heap_top      <= heap_top_next;
      largest_freed <= largest_freed_next;
      heap_base     <= heap_base_next;
      heap_limit    <= heap_limit_next;
      header_bytes  <= header_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q     <= kind_q_next;
    size_q     <= size_q_next;
    addr_q     <= addr_q_next;
    at         <= at_next;
    n          <= n_next;
    tmp        <= tmp_next;
    rem        <= rem_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      granted_address <= res_addr;
      status          <= res_status;
    end
  end

  always_comb begin
    state_next         = state;
    kind_q_next        = kind_q;
    size_q_next        = size_q;
    addr_q_next        = addr_q;
    at_next            = at;
    n_next             = n;
    tmp_next           = tmp;
    rem_next           = rem;
    res_addr_next      = res_addr;
    res_status_next    = res_status;
    count_next         = count;
    tail_next          = tail;
    heap_top_next      = heap_top;
    largest_freed_next = largest_freed;
    heap_base_next     = heap_base;
    heap_limit_next    = heap_limit;
    header_bytes_next  = header_bytes;
    out_load           = 1'b0;
    alu_a              = '0;
    alu_b              = '0;
    alu_sub            = 1'b0;
    rd_addr            = at;
    wr_addr            = at;
    wr_mask            = '0;
    wr_data            = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_q_next = kind;
          size_q_next = request_size;
          addr_q_next = release_address;
          at_next     = '0;
          n_next      = '0;
          rd_addr     = '0;
          state_next  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        alu_a         = ALU_W'(largest_freed);
        alu_b         = ALU_W'(size_q);
        alu_sub       = 1'b1;
        res_addr_next = '0;
        if (kind_q == KIND_FREE) begin
          if (count == '0) begin
            res_status_next = ST_NOTFOUND;
            state_next      = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end else if (size_q == '0) begin
          res_status_next = ST_NULL;
          state_next      = S_FINISH;
        end else if (count == '0 || alu.borrow) begin
          state_next = S_APP_SUM;
        end else begin
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        alu_sub = 1'b1;
        if (kind_q == KIND_FREE) begin
          alu_a = ALU_W'(rd.start);
          alu_b = ALU_W'(addr_q);
        end else begin
          alu_a = ALU_W'(rd.length);
          alu_b = ALU_W'(size_q);
        end
        if (kind_q == KIND_FREE && alu.zero) begin
          wr_mask.is_free = 1'b1;
          wr_data.is_free = 1'b1;
          state_next      = S_FREE_MAX;
        end else if (kind_q == KIND_ALLOC && rd.is_free && alu.zero) begin
          wr_mask.is_free = 1'b1;
          wr_data.is_free = 1'b0;
          res_addr_next   = rd.start;
          res_status_next = ST_OK;
          state_next      = S_FINISH;
        end else if (kind_q == KIND_ALLOC && rd.is_free && !alu.borrow) begin
          rem_next   = alu.sum[ADDR_W-1:0];
          state_next = S_SPLIT_TOP;
        end else if (n_inc == count) begin
          if (kind_q == KIND_FREE) begin
            res_status_next = ST_NOTFOUND;
            state_next      = S_FINISH;
          end else begin
            state_next = S_APP_SUM;
          end
        end else begin
          n_next  = n_inc;
          at_next = rd.link;
          rd_addr = rd.link;
        end
      end

      S_FREE_MAX: begin
        alu_a   = ALU_W'(largest_freed);
        alu_b   = ALU_W'(rd.length);
        alu_sub = 1'b1;
        if (alu.borrow) begin
          largest_freed_next = rd.length;
        end
        res_status_next = ST_OK;
        state_next      = S_FINISH;
      end

      S_SPLIT_TOP: begin
        alu_a    = ALU_W'(heap_top);
        alu_b    = ALU_W'(header_bytes);
        tmp_next = alu.sum;
        if (table_full) begin
          res_status_next = ST_NOMEM;
          state_next      = S_FINISH;
        end else begin
          state_next = S_SPLIT_LIM;
        end
      end

      S_SPLIT_LIM: begin
        alu_a   = ALU_W'(heap_limit);
        alu_b   = tmp;
        alu_sub = 1'b1;
        if (alu.borrow) begin
          res_status_next = ST_NOMEM;
          state_next      = S_FINISH;
        end else begin
          state_next = S_SPLIT_NEW;
        end
      end

      S_SPLIT_NEW: begin
        alu_a           = ALU_W'(rd.start);
        alu_b           = ALU_W'(size_q);
        wr_addr         = new_idx;
        wr_mask         = '1;
        wr_data.start   = alu.sum[ADDR_W-1:0];
        wr_data.length  = rem;
        wr_data.is_free = 1'b1;
        wr_data.link    = rd.link;
        state_next      = S_SPLIT_OLD;
      end

      S_SPLIT_OLD: begin
        wr_mask.length  = 1'b1;
        wr_mask.is_free = 1'b1;
        wr_mask.link    = 1'b1;
        wr_data.length  = size_q;
        wr_data.is_free = 1'b0;
        wr_data.link    = new_idx;
        if (tail == at) begin
          tail_next = new_idx;
        end
        count_next      = count + 1'b1;
        heap_top_next   = tmp[ADDR_W-1:0];
        res_addr_next   = rd.start;
        res_status_next = ST_OK;
        state_next      = S_FINISH;
      end

      S_APP_SUM: begin
        alu_a    = ALU_W'(heap_top);
        alu_b    = ALU_W'(size_q);
        tmp_next = alu.sum;
        if (table_full) begin
          res_status_next = ST_NOMEM;
          state_next      = S_FINISH;
        end else begin
          state_next = S_APP_TOP;
        end
      end

      S_APP_TOP: begin
        alu_a      = tmp;
        alu_b      = ALU_W'(header_bytes);
        tmp_next   = alu.sum;
        state_next = S_APP_LIM;
      end

      S_APP_LIM: begin
        alu_a   = ALU_W'(heap_limit);
        alu_b   = tmp;
        alu_sub = 1'b1;
        if (alu.borrow) begin
          res_status_next = ST_NOMEM;
          state_next      = S_FINISH;
        end else begin
          state_next = S_APP_NEW;
        end
      end

      S_APP_NEW: begin
        alu_a           = ALU_W'(heap_top);
        alu_b           = ALU_W'(header_bytes);
        wr_addr         = new_idx;
        wr_mask         = '1;
        wr_data.start   = alu.sum[ADDR_W-1:0];
        wr_data.length  = size_q;
        wr_data.is_free = 1'b0;
        wr_data.link    = '0;
        res_addr_next   = alu.sum[ADDR_W-1:0];
        state_next      = S_APP_LINK;
      end

      S_APP_LINK: begin
        wr_addr      = tail;
        wr_mask.link = (count != '0);
        wr_data.link = new_idx;
        tail_next       = new_idx;
        count_next      = count + 1'b1;
        heap_top_next   = tmp[ADDR_W-1:0];
        res_status_next = ST_OK;
        state_next      = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // config writes are to arrive only while idle; the user must keep to this, the block does not enforce it
    if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_HEAP_BASE: begin
          heap_base_next = cfg_data;
          if (count == '0) begin
            heap_top_next = cfg_data;
          end
        end
        REG_HEAP_LIMIT: begin
          heap_limit_next = cfg_data;
        end
        REG_HEADER_BYTES: begin
          header_bytes_next = cfg_data[HDR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/ffsa_checker.sv]
// Port-level checks for first_fit_segment_allocator, bound to the top level.
// Depends on ffsa_pkg.
`default_nettype none

module ffsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ffsa_pkg::ADDR_W-1:0] granted_address,
  input logic [1:0]                  status
);
  import ffsa_pkg::*;

  // after a request is taken, in_ready stays low through the decide and finish states
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready ##1 !in_ready))
    else $error("request channel ready too soon after a request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(granted_address) && $stable(status)))
    else $error("stalled result changed");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_address == '0))
    else $error("failed request carries an address");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while sequencer idle");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// Testbench for first_fit_segment_allocator: directed and random allocate and
// free requests, each checked against a segment-table predictor kept here.
// Depends on ffsa_pkg and the first_fit_segment_allocator RTL.
`timescale 1ns / 100ps

module testbench;
  import ffsa_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [ADDR_W-1:0] address;
    status_t           code;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_ALLOC;
  logic [ADDR_W-1:0] request_size = '0;
  logic [ADDR_W-1:0] release_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] granted_address;
  logic [1:0]        status;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned ready_idle_pct = 0;
  int          mismatch_count = 0;
  grant_t      predicted_grants[$];

  // predictor state
  logic [ADDR_W-1:0] heap_base_q;
  logic [ADDR_W-1:0] heap_limit_q;
  logic [HDR_W-1:0]  header_len;
  logic [ADDR_W-1:0] seg_start [SEGMENTS];
  logic [ADDR_W-1:0] seg_len [SEGMENTS];
  logic              seg_free [SEGMENTS];
  logic [IDX_W-1:0]  seg_next [SEGMENTS];
  int                seg_count;
  logic [IDX_W-1:0]  list_tail;
  logic [ADDR_W-1:0] heap_top;
  logic [ADDR_W-1:0] largest_freed;

  first_fit_segment_allocator i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .request_size    (request_size),
    .release_address (release_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted_address (granted_address),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
  end

  always @(posedge clk) begin
    grant_t exp;
    if (!rst && out_valid && out_ready) begin
      if (predicted_grants.size() == 0) begin
        $error("unexpected result: granted_address %h status %0d", granted_address, status);
        mismatch_count++;
      end else begin
        exp = predicted_grants.pop_front();
        if (granted_address !== exp.address) begin
          $error("granted_address: expected %h, actual %h", exp.address, granted_address);
          mismatch_count++;
        end
        if (status !== exp.code) begin
          $error("status: expected %0d, actual %0d", exp.code, status);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void reset_allocator_model();
    heap_base_q   = '0;
    heap_limit_q  = '1;
    header_len    = 8'd32;
    seg_count     = 0;
    list_tail     = '0;
    heap_top      = heap_base_q;
    largest_freed = '0;
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
    case (idx)
      REG_HEAP_BASE: begin
        heap_base_q = data;
        if (seg_count == 0) heap_top = data;
      end
      REG_HEAP_LIMIT: heap_limit_q = data;
      REG_HEADER_BYTES: header_len = data[HDR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic status_t append_segment(input logic [ADDR_W-1:0] size,
                                             output logic [ADDR_W-1:0] addr);
    logic [ALU_W-1:0] grown;
    grown = ALU_W'(heap_top) + ALU_W'(size) + ALU_W'(header_len);
    addr = '0;
    if (seg_count >= SEGMENTS || grown > ALU_W'(heap_limit_q)) return ST_NOMEM;
    seg_start[seg_count] = heap_top + ADDR_W'(header_len);
    seg_len[seg_count]   = size;
    seg_free[seg_count]  = 1'b0;
    seg_next[seg_count]  = '0;
    if (seg_count > 0) seg_next[list_tail] = IDX_W'(seg_count);
    list_tail = IDX_W'(seg_count);
    seg_count++;
    heap_top = grown[ADDR_W-1:0];
    addr = seg_start[list_tail];
    return ST_OK;
  endfunction

  function automatic status_t allocate_segment(input logic [ADDR_W-1:0] size,
                                               output logic [ADDR_W-1:0] addr);
    int               at;
    int               slot;
    logic [ALU_W-1:0] grown;
    addr = '0;
    if (size == 0) return ST_NULL;
    if (seg_count == 0 || size > largest_freed) return append_segment(size, addr);
    at = 0;
    for (int n = 0; n < seg_count; n++) begin
      if (seg_free[at] && seg_len[at] == size) begin
        seg_free[at] = 1'b0;
        addr = seg_start[at];
        return ST_OK;
      end
      if (seg_free[at] && seg_len[at] > size) begin
        grown = ALU_W'(heap_top) + ALU_W'(header_len);
        if (seg_count >= SEGMENTS || grown > ALU_W'(heap_limit_q)) return ST_NOMEM;
        slot = seg_count;
        seg_start[slot] = seg_start[at] + size;
        seg_len[slot]   = seg_len[at] - size;
        seg_free[slot]  = 1'b1;
        seg_next[slot]  = seg_next[at];
        seg_next[at]    = IDX_W'(slot);
        seg_len[at]     = size;
        seg_free[at]    = 1'b0;
        if (list_tail == IDX_W'(at)) list_tail = IDX_W'(slot);
        seg_count++;
        heap_top = grown[ADDR_W-1:0];
        addr = seg_start[at];
        return ST_OK;
      end
      at = seg_next[at];
    end
    return append_segment(size, addr);
  endfunction

  function automatic status_t release_segment(input logic [ADDR_W-1:0] address);
    int at;
    at = 0;
    for (int n = 0; n < seg_count; n++) begin
      if (seg_start[at] == address) begin
        seg_free[at] = 1'b1;
        if (seg_len[at] > largest_freed) largest_freed = seg_len[at];
        return ST_OK;
      end
      at = seg_next[at];
    end
    return ST_NOTFOUND;
  endfunction

  function automatic void compute_grant(input logic k, input logic [ADDR_W-1:0] size,
                                        input logic [ADDR_W-1:0] address);
    grant_t            g;
    logic [ADDR_W-1:0] addr;
    if (k == KIND_ALLOC) begin
      g.code = allocate_segment(size, addr);
      g.address = addr;
    end else begin
      g.code = release_segment(address);
      g.address = '0;
    end
    predicted_grants.push_back(g);
  endfunction

  task automatic send_request(input logic k, input logic [ADDR_W-1:0] size,
                              input logic [ADDR_W-1:0] address);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    kind            <= k;
    request_size    <= size;
    release_address <= address;
    do @(posedge clk); while (!in_ready);
    compute_grant(k, size, address);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_grants.size() != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_size();
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return $urandom();
    if (r < 35 && seg_count > 0) begin
      idx = $urandom_range(0, seg_count - 1);
      if ($urandom_range(0, 1) == 0) return seg_len[idx];
      return $urandom_range(1, seg_len[idx]);
    end
    if (r < 75) return 8 * $urandom_range(1, 8);
    return $urandom_range(1, 4096);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_release();
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (seg_count > 0) begin
      idx = $urandom_range(0, seg_count - 1);
      if (r < 75) return seg_start[idx];
      if (r < 88) return seg_start[idx] + 1;
    end
    return $urandom();
  endfunction

  task automatic test_empty_table();
    // heap top at the very top: nothing fits
    write_register(REG_HEAP_BASE, '1);
    send_request(KIND_ALLOC, 32'd1, '0);
    send_request(KIND_FREE, '0, '0);
    drain();
    write_register(REG_HEAP_BASE, 32'h0000_1000);
    write_register(REG_UNUSED, '0);
    send_request(KIND_ALLOC, '0, '1);
  endtask

  task automatic test_first_fit();
    send_request(KIND_ALLOC, 32'd64, '0);
    send_request(KIND_ALLOC, 32'd32, '0);
    send_request(KIND_FREE, '1, 32'h0000_1020);
    send_request(KIND_FREE, '0, 32'h0000_1020);
    send_request(KIND_FREE, '0, 32'h0000_1021);
    send_request(KIND_ALLOC, 32'd64, '0);
    send_request(KIND_FREE, '0, 32'h0000_1080);
    // split of the tail, then exact fit on the remainder
    send_request(KIND_ALLOC, 32'd16, '0);
    send_request(KIND_ALLOC, 32'd16, '0);
    send_request(KIND_ALLOC, 32'd65, '0);
    send_request(KIND_FREE, '0, 32'h0000_1020);
    send_request(KIND_ALLOC, 32'd48, '0);
    // scan finds nothing, heap grows instead
    send_request(KIND_ALLOC, 32'd64, '0);
    drain();
    write_register(REG_HEAP_BASE, '0);
    send_request(KIND_ALLOC, 32'd8, '0);
    drain();
  endtask

  task automatic test_heap_limit();
    write_register(REG_HEAP_LIMIT, heap_top + 32'd40);
    send_request(KIND_ALLOC, 32'd8, '0);
    send_request(KIND_ALLOC, 32'd1, '0);
    send_request(KIND_FREE, '0, 32'h0000_10E0);
    send_request(KIND_ALLOC, 32'd10, '0);
    send_request(KIND_ALLOC, 32'd16, '0);
    drain();
    write_register(REG_HEAP_LIMIT, '0);
    send_request(KIND_ALLOC, 32'd100, '0);
    send_request(KIND_ALLOC, '1, '0);
    send_request(KIND_FREE, '0, '1);
    drain();
  endtask

  task automatic random_traffic(input int count, input int unsigned send_pct,
                                input int unsigned ready_pct, input logic [HDR_W-1:0] hdr,
                                input logic [ADDR_W-1:0] limit);
    drain();
    send_idle_pct  = send_pct;
    ready_idle_pct = ready_pct;
    write_register(REG_HEADER_BYTES, ADDR_W'(hdr));
    write_register(REG_HEAP_LIMIT, limit);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) send_request(KIND_ALLOC, pick_size(), $urandom());
      else send_request(KIND_FREE, $urandom(), pick_release());
    end
  endtask

  initial begin
    reset_allocator_model();
    send_idle_pct  = 21;
    ready_idle_pct = 56;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_first_fit();
    test_heap_limit();
    random_traffic(360, 21, 56, 8'd8, '1);
    random_traffic(360, 56, 21, 8'd0, heap_top + 32'h0004_0000);
    random_traffic(360, 0, 0, 8'd255, '1);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_grants.size() == 0) begin
      $display("first_fit_segment_allocator test passed");
    end else begin
      $display("first_fit_segment_allocator test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("first_fit_segment_allocator test failed");
    $finish;
  end

endmodule

[filelist.f]
sv/ffsa_pkg.sv
sv/ffsa_alu.sv
sv/ffsa_table.sv
sv/first_fit_segment_allocator.sv
sv/ffsa_checker.sv
dv/testbench.sv
